// ===== design/wfst_pkg.sv =====
// Shared types and constants of the wide frame serial transmitter.
package wfst_pkg;

  // Frame geometry
  localparam int MAX_DATA_BYTES = 4;
  localparam int MIN_DATA_BYTES = 2;
  localparam int DATA_W         = 32;
  localparam int BYTE_SHIFT     = 3;
  localparam int FRAME_BITS_MAX = MAX_DATA_BYTES * 8;
  localparam int BIT_POS_W      = $clog2(FRAME_BITS_MAX);

  // Configuration register widths
  localparam int DB_W       = 3;
  localparam int PM_W       = 3;
  localparam int SB_W       = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DATA_BYTES  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARITY_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_BITS   = 2'd2;

  // Parity modes; every mode but none sends a space bit
  localparam logic [PM_W-1:0] PAR_NONE  = 3'd0;
  localparam logic [PM_W-1:0] PAR_ODD   = 3'd1;
  localparam logic [PM_W-1:0] PAR_EVEN  = 3'd2;
  localparam logic [PM_W-1:0] PAR_MARK  = 3'd3;
  localparam logic [PM_W-1:0] PAR_SPACE = 3'd4;

  // One input request: a bit-period tick
  typedef struct packed {
    logic              send_request;
    logic [DATA_W-1:0] frame_data;
  } in_item_t;

  // One result: the line level of the tick, a busy flag and a frame-done flag
  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic frame_done;
  } out_item_t;

  // Configuration register set
  typedef struct packed {
    logic [DB_W-1:0] data_bytes;
    logic [PM_W-1:0] parity_mode;
    logic [SB_W-1:0] stop_bits;
  } cfg_t;

endpackage

// ===== design/wfst_in_stage.sv =====
// Input register stage: holds one accepted request until the core consumes it.
module wfst_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  wfst_pkg::in_item_t in_data,
  input  logic              step,
  output logic              held_valid,
  output wfst_pkg::in_item_t held_data
);

  logic               valid_r;
  logic               valid_nxt;
  wfst_pkg::in_item_t data_r;

  // Accept when empty or when the held request moves on this cycle
  assign in_ready = !valid_r || step;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (step) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Capture payload on acceptance
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

  assign held_valid = valid_r;
  assign held_data  = data_r;

endmodule

// ===== design/wfst_core.sv =====
// Frame sequencer: state registers and the per-tick line level logic.
module wfst_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  wfst_pkg::in_item_t  tick,
  input  wfst_pkg::cfg_t      cfg,
  output wfst_pkg::out_item_t result
);

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_START  = 5'b00010,
    PH_DATA   = 5'b00100,
    PH_PARITY = 5'b01000,
    PH_STOP   = 5'b10000
  } phase_t;

  localparam int PW = wfst_pkg::BIT_POS_W;

  phase_t                        phase_r;
  phase_t                        phase_nxt;
  logic [PW-1:0]                 bit_pos_r;
  logic [PW-1:0]                 bit_pos_nxt;
  logic [wfst_pkg::DATA_W-1:0]   held_r;
  logic [wfst_pkg::DATA_W-1:0]   held_nxt;
  logic [wfst_pkg::FRAME_BITS_MAX-1:0] held_wide;
  logic [wfst_pkg::SB_W-1:0]     stop_cnt_r;
  logic [wfst_pkg::SB_W-1:0]     stop_cnt_nxt;
  logic [wfst_pkg::SB_W-1:0]     stop_inc;
  logic [wfst_pkg::DB_W-1:0]     nbytes;
  logic [PW:0]                   frame_bits;
  logic [PW:0]                   pos_inc;
  logic                          parity_on;
  logic                          no_stop;
  logic                          line;
  logic                          done;

  // Clamp the byte count and derive the data length in bits
  always_comb begin
    nbytes = cfg.data_bytes;
    if (cfg.data_bytes < wfst_pkg::DB_W'(wfst_pkg::MIN_DATA_BYTES)) begin
      nbytes = wfst_pkg::DB_W'(wfst_pkg::MIN_DATA_BYTES);
    end else if (int'(cfg.data_bytes) > wfst_pkg::MAX_DATA_BYTES) begin
      nbytes = wfst_pkg::DB_W'(wfst_pkg::MAX_DATA_BYTES);
    end
  end

  assign frame_bits = (PW+1)'(nbytes) << wfst_pkg::BYTE_SHIFT;
  assign pos_inc    = {1'b0, bit_pos_r} + (PW+1)'(1);
  assign parity_on  = (cfg.parity_mode != wfst_pkg::PAR_NONE);
  assign no_stop    = (cfg.stop_bits == '0);
  assign stop_inc   = stop_cnt_r + wfst_pkg::SB_W'(1);

  // Extend the held word to the frame length; bits past the word send low
  assign held_wide  = wfst_pkg::FRAME_BITS_MAX'(held_r);

  // Advance the frame by one bit period
  always_comb begin
    phase_nxt    = phase_r;
    bit_pos_nxt  = bit_pos_r;
    held_nxt     = held_r;
    stop_cnt_nxt = stop_cnt_r;
    line         = 1'b1;
    done         = 1'b0;
    case (phase_r)
      PH_IDLE: begin
        if (tick.send_request) begin
          held_nxt     = tick.frame_data;
          bit_pos_nxt  = '0;
          stop_cnt_nxt = '0;
          phase_nxt    = PH_START;
        end
      end
      PH_START: begin
        line        = 1'b0;
        bit_pos_nxt = '0;
        phase_nxt   = PH_DATA;
      end
      PH_DATA: begin
        line        = held_wide[bit_pos_r];
        bit_pos_nxt = pos_inc[PW-1:0];
        if (pos_inc >= frame_bits) begin
          bit_pos_nxt = '0;
          if (!parity_on && no_stop) begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end else begin
            phase_nxt = PH_PARITY;
          end
        end
      end
      PH_PARITY: begin
        if (parity_on) begin
          // Parity is always sent as space
          line = 1'b0;
          if (no_stop) begin
            phase_nxt = PH_IDLE;
            done      = 1'b1;
          end else begin
            phase_nxt = PH_STOP;
          end
        end else if (no_stop) begin
          phase_nxt = PH_IDLE;
          done      = 1'b1;
        end else if (stop_inc == cfg.stop_bits) begin
          // First stop bit right after the data
          stop_cnt_nxt = '0;
          phase_nxt    = PH_IDLE;
          done         = 1'b1;
        end else begin
          stop_cnt_nxt = stop_inc;
          phase_nxt    = PH_STOP;
        end
      end
      PH_STOP: begin
        if (no_stop || stop_cnt_r >= cfg.stop_bits) begin
          stop_cnt_nxt = '0;
          phase_nxt    = PH_IDLE;
          done         = 1'b1;
        end else if (stop_inc == cfg.stop_bits) begin
          stop_cnt_nxt = '0;
          phase_nxt    = PH_IDLE;
          done         = 1'b1;
        end else begin
          stop_cnt_nxt = stop_inc;
          phase_nxt    = PH_STOP;
        end
      end
      default: begin
        phase_nxt = PH_IDLE;
      end
    endcase
  end

  // Update state only when a tick is consumed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      bit_pos_r  <= '0;
      stop_cnt_r <= '0;
    end else if (step) begin
      phase_r    <= phase_nxt;
      bit_pos_r  <= bit_pos_nxt;
      stop_cnt_r <= stop_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      held_r <= held_nxt;
    end
  end

  assign result.line_level = line;
  assign result.busy_res   = (phase_nxt != PH_IDLE);
  assign result.frame_done = done;

endmodule

// ===== design/wfst_out_stage.sv =====
// Result register: holds one result until the receiver takes it.
module wfst_out_stage (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                load,
  input  wfst_pkg::out_item_t load_data,
  output logic                free,
  output logic                out_valid,
  input  logic                out_ready,
  output wfst_pkg::out_item_t out_data
);

  logic                valid_r;
  logic                valid_nxt;
  wfst_pkg::out_item_t data_r;

  // Room for a new result when empty or when the current one leaves now
  assign free = !valid_r || out_ready;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= load_data;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== design/wide_frame_serial_transmitter.sv =====
// Top level of the wide frame serial transmitter.
//
// Each request on the in_ channel is one bit-period tick; each tick yields
// exactly one result on the out_ channel carrying the line level for that
// period, a busy flag and a frame-done flag. A tick with send_request high
// while idle captures frame_data; the start bit follows on the next tick,
// then 2 to 4 data bytes LSB first, an optional space parity bit and the
// configured number of high stop bits.
// An accepted request waits in the input register and is loaded into the
// result register once that register has room; its result is then valid.
// Throughput: one tick per cycle unless the receiver stalls; the input register
// and result register overlap, and the frame state updates once per tick.
// The cfg_ channel writes data_bytes (0), parity_mode (1), stop_bits (2);
// it is always ready, and other indexes are dropped.
// Reset (synchronous, rst_n low) empties both registers, returns the
// sequencer to idle and loads data_bytes 4, parity_mode 4, stop_bits 1.
// When the receiver stalls, the result register holds its value and the
// input register fills; in_ready then drops until out_ready returns.
module wide_frame_serial_transmitter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  wfst_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output wfst_pkg::out_item_t                 out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [wfst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wfst_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  localparam logic [wfst_pkg::DB_W-1:0] RST_DATA_BYTES  = 3'd4;
  localparam logic [wfst_pkg::PM_W-1:0] RST_PARITY_MODE = 3'd4;
  localparam logic [wfst_pkg::SB_W-1:0] RST_STOP_BITS   = 2'd1;

  wfst_pkg::cfg_t      cfg_r;
  wfst_pkg::cfg_t      cfg_nxt;
  wfst_pkg::in_item_t  held_data;
  wfst_pkg::out_item_t core_result;
  logic                held_valid;
  logic                out_free;
  logic                step;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        wfst_pkg::REG_DATA_BYTES: begin
          cfg_nxt.data_bytes = cfg_wdata[wfst_pkg::DB_W-1:0];
        end
        wfst_pkg::REG_PARITY_MODE: begin
          cfg_nxt.parity_mode = cfg_wdata[wfst_pkg::PM_W-1:0];
        end
        wfst_pkg::REG_STOP_BITS: begin
          cfg_nxt.stop_bits = cfg_wdata[wfst_pkg::SB_W-1:0];
        end
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.data_bytes  <= RST_DATA_BYTES;
      cfg_r.parity_mode <= RST_PARITY_MODE;
      cfg_r.stop_bits   <= RST_STOP_BITS;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Move a tick from the input register into the result register
  assign step = held_valid && out_free;

  wfst_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .step       (step),
    .held_valid (held_valid),
    .held_data  (held_data)
  );

  wfst_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .tick   (held_data),
    .cfg    (cfg_r),
    .result (core_result)
  );

  wfst_out_stage u_out_stage (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (step),
    .load_data (core_result),
    .free      (out_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // A finished frame never reports busy in the same result
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.frame_done && out_data.busy_res))
    else $error("frame_done with busy_res set");

  // An empty result register never blocks the input
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // Every consumed tick produces a result
  a_step_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_valid)
    else $error("consumed tick produced no result");

endmodule

// ===== dv/tb_wide_frame_serial_transmitter.sv =====
// Self-checking testbench for the wide frame serial transmitter.
module tb_wide_frame_serial_transmitter;
  timeunit 1ns;
  timeprecision 1ps;

  // Register indexes and parity codes
  localparam logic [wfst_pkg::CFG_IDX_W-1:0] REG_DATA_BYTES = wfst_pkg::REG_DATA_BYTES;
  localparam logic [wfst_pkg::CFG_IDX_W-1:0] REG_PARITY     = wfst_pkg::REG_PARITY_MODE;
  localparam logic [wfst_pkg::CFG_IDX_W-1:0] REG_STOP_BITS  = wfst_pkg::REG_STOP_BITS;
  localparam logic [wfst_pkg::CFG_IDX_W-1:0] REG_UNUSED     = 2'd3;

  localparam logic [wfst_pkg::PM_W-1:0] PAR_NONE  = wfst_pkg::PAR_NONE;
  localparam logic [wfst_pkg::PM_W-1:0] PAR_ODD   = wfst_pkg::PAR_ODD;
  localparam logic [wfst_pkg::PM_W-1:0] PAR_EVEN  = wfst_pkg::PAR_EVEN;
  localparam logic [wfst_pkg::PM_W-1:0] PAR_MARK  = wfst_pkg::PAR_MARK;
  localparam logic [wfst_pkg::PM_W-1:0] PAR_SPACE = wfst_pkg::PAR_SPACE;

  // Result patterns that can be read off directly: {line, busy, done}
  localparam wfst_pkg::out_item_t LVL_NONE       = 3'b000;
  localparam wfst_pkg::out_item_t LVL_IDLE       = 3'b100;
  localparam wfst_pkg::out_item_t LVL_MARK_BUSY  = 3'b110;
  localparam wfst_pkg::out_item_t LVL_SPACE_BUSY = 3'b010;
  localparam wfst_pkg::out_item_t LVL_MARK_DONE  = 3'b101;

  localparam int CYCLE_LIMIT   = 200000;
  localparam int NUM_SEGMENTS  = 12;
  localparam int SEGMENT_ITEMS = 110;

  // One row of the directed sequence: a register write or a run of ticks
  typedef struct packed {
    logic                            is_cfg;
    logic [wfst_pkg::CFG_IDX_W-1:0]  idx;
    logic [wfst_pkg::CFG_DATA_W-1:0] wdata;
    logic [5:0]                      reps;
    logic                            req;
    logic [wfst_pkg::DATA_W-1:0]     word;
    logic                            typed;
    wfst_pkg::out_item_t             level;
  } dir_row_t;

  localparam dir_row_t DIRECTED [15] = '{
    '{1'b0, REG_UNUSED,     3'd0,      6'd1,  1'b0, 32'h0000_0000, 1'b1, LVL_IDLE},
    '{1'b1, REG_UNUSED,     3'd7,      6'd0,  1'b0, 32'h0000_0000, 1'b0, LVL_NONE},
    '{1'b1, REG_DATA_BYTES, 3'd0,      6'd0,  1'b0, 32'h0000_0000, 1'b0, LVL_NONE},
    '{1'b1, REG_PARITY,     PAR_NONE,  6'd0,  1'b0, 32'h0000_0000, 1'b0, LVL_NONE},
    '{1'b1, REG_STOP_BITS,  3'd0,      6'd0,  1'b0, 32'h0000_0000, 1'b0, LVL_NONE},
    '{1'b0, REG_UNUSED,     3'd0,      6'd1,  1'b1, 32'hFFFF_FFFF, 1'b1, LVL_MARK_BUSY},
    '{1'b0, REG_UNUSED,     3'd0,      6'd1,  1'b1, 32'h0000_0000, 1'b1, LVL_SPACE_BUSY},
    '{1'b0, REG_UNUSED,     3'd0,      6'd15, 1'b0, 32'h0000_0000, 1'b1, LVL_MARK_BUSY},
    '{1'b0, REG_UNUSED,     3'd0,      6'd1,  1'b0, 32'h0000_0000, 1'b1, LVL_MARK_DONE},
    '{1'b0, REG_UNUSED,     3'd0,      6'd1,  1'b0, 32'h0000_0000, 1'b1, LVL_IDLE},
    '{1'b1, REG_PARITY,     3'd7,      6'd0,  1'b0, 32'h0000_0000, 1'b0, LVL_NONE},
    '{1'b1, REG_STOP_BITS,  3'd3,      6'd0,  1'b0, 32'h0000_0000, 1'b0, LVL_NONE},
    '{1'b0, REG_UNUSED,     3'd0,      6'd1,  1'b1, 32'h8000_0001, 1'b1, LVL_MARK_BUSY},
    '{1'b0, REG_UNUSED,     3'd0,      6'd1,  1'b0, 32'h0000_0000, 1'b1, LVL_SPACE_BUSY},
    '{1'b0, REG_UNUSED,     3'd0,      6'd3,  1'b0, 32'h0000_0000, 1'b0, LVL_NONE}
  };

  // Settings for the first random segments, extremes among them
  localparam logic [2:0] PLAN_BYTES  [8] = '{3'd2, 3'd4, 3'd7, 3'd0, 3'd3, 3'd4, 3'd2, 3'd1};
  localparam logic [2:0] PLAN_PARITY [8] = '{PAR_NONE, PAR_SPACE, 3'd7, PAR_ODD,
                                             PAR_NONE, PAR_EVEN, 3'd5, PAR_MARK};
  localparam logic [2:0] PLAN_STOPS  [8] = '{3'd0, 3'd1, 3'd3, 3'd2, 3'd1, 3'd3, 3'd0, 3'd6};

  typedef enum logic [2:0] {ST_IDLE, ST_START, ST_DATA, ST_PARITY, ST_STOP} tx_phase_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  wfst_pkg::in_item_t              in_data;
  logic                            out_valid;
  logic                            out_ready;
  wfst_pkg::out_item_t             out_data;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [wfst_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [wfst_pkg::CFG_DATA_W-1:0] cfg_wdata;

  // Transmitter shadow: configuration and frame sequencer
  logic [wfst_pkg::DB_W-1:0]   cfg_bytes  = 3'd4;
  logic [wfst_pkg::PM_W-1:0]   cfg_parity = PAR_SPACE;
  logic [wfst_pkg::SB_W-1:0]   cfg_stops  = 2'd1;
  tx_phase_t                   seq_phase  = ST_IDLE;
  logic [5:0]                  bit_pos    = '0;
  logic [wfst_pkg::DATA_W-1:0] held_word  = '0;
  logic [wfst_pkg::SB_W-1:0]   stop_cnt   = '0;
  logic                        line_reg   = 1'b1;

  wfst_pkg::out_item_t pending_levels [$];
  int                  err_count       = 0;
  int                  cycle_cnt       = 0;
  int                  sender_idle_pct = 0;
  int                  stall_pct       = 0;

  wide_frame_serial_transmitter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One high stop period; returns 1 when the frame ends
  function automatic logic stop_period();
    line_reg = 1'b1;
    stop_cnt = stop_cnt + 1'b1;
    if (stop_cnt == cfg_stops) begin
      stop_cnt  = '0;
      seq_phase = ST_IDLE;
      return 1'b1;
    end
    seq_phase = ST_STOP;
    return 1'b0;
  endfunction

  // Advance the shadow sequencer by one tick and return its line level
  function automatic wfst_pkg::out_item_t line_for_tick(input wfst_pkg::in_item_t req);
    logic                done;
    int unsigned         nbits;
    wfst_pkg::out_item_t lvl;
    done = 1'b0;
    if (cfg_bytes < wfst_pkg::MIN_DATA_BYTES) nbits = wfst_pkg::MIN_DATA_BYTES * 8;
    else if (cfg_bytes > wfst_pkg::MAX_DATA_BYTES) nbits = wfst_pkg::FRAME_BITS_MAX;
    else nbits = cfg_bytes * 8;
    case (seq_phase)
      ST_IDLE: begin
        line_reg = 1'b1;
        if (req.send_request) begin
          held_word = req.frame_data;
          bit_pos   = '0;
          stop_cnt  = '0;
          seq_phase = ST_START;
        end
      end
      ST_START: begin
        line_reg  = 1'b0;
        bit_pos   = '0;
        seq_phase = ST_DATA;
      end
      ST_DATA: begin
        line_reg = (bit_pos < wfst_pkg::DATA_W) ? held_word[bit_pos[4:0]] : 1'b0;
        bit_pos  = bit_pos + 1'b1;
        if (bit_pos >= nbits) begin
          bit_pos = '0;
          if (cfg_parity != PAR_NONE) begin
            seq_phase = ST_PARITY;
          end else if (cfg_stops == 0) begin
            seq_phase = ST_IDLE;
            done      = 1'b1;
          end else begin
            seq_phase = ST_PARITY;
          end
        end
      end
      ST_PARITY: begin
        if (cfg_parity != PAR_NONE) begin
          line_reg = 1'b0;
          if (cfg_stops == 0) begin
            seq_phase = ST_IDLE;
            done      = 1'b1;
          end else begin
            seq_phase = ST_STOP;
          end
        end else if (cfg_stops == 0) begin
          line_reg  = 1'b1;
          seq_phase = ST_IDLE;
          done      = 1'b1;
        end else begin
          done = stop_period();
        end
      end
      ST_STOP: begin
        if (cfg_stops == 0 || stop_cnt >= cfg_stops) begin
          line_reg  = 1'b1;
          stop_cnt  = '0;
          seq_phase = ST_IDLE;
          done      = 1'b1;
        end else begin
          done = stop_period();
        end
      end
      default: begin
        line_reg  = 1'b1;
        seq_phase = ST_IDLE;
      end
    endcase
    lvl.line_level = line_reg;
    lvl.busy_res   = (seq_phase != ST_IDLE);
    lvl.frame_done = done;
    return lvl;
  endfunction

  task automatic report_mismatch(input string what, input logic got, input logic want);
    if (err_count < 40)
      $display("ERROR cycle %0d: %s got %0b expected %0b", cycle_cnt, what, got, want);
    err_count++;
  endtask

  // Send one tick request, with random sender gaps, and record its expected level
  task automatic send_tick(input logic req, input logic [wfst_pkg::DATA_W-1:0] word,
                           input logic typed, input wfst_pkg::out_item_t level);
    wfst_pkg::in_item_t  item;
    wfst_pkg::out_item_t predicted;
    item.send_request = req;
    item.frame_data   = word;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= item;
    do @(posedge clk); while (!in_ready);
    predicted = line_for_tick(item);
    pending_levels.push_back(typed ? level : predicted);
  endtask

  // Hold the sender until every expected level has come back
  task automatic drain_levels();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk);
  endtask

  // Write one register and mirror it in the shadow
  task automatic write_reg(input logic [wfst_pkg::CFG_IDX_W-1:0] idx,
                           input logic [wfst_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_DATA_BYTES: cfg_bytes  = val;
      REG_PARITY:     cfg_parity = val;
      REG_STOP_BITS:  cfg_stops  = val[wfst_pkg::SB_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Receiver: stall at random
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Compare each accepted level with the oldest expectation
  always @(posedge clk) begin : check_levels
    wfst_pkg::out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_levels.size() == 0) begin
        report_mismatch("result with nothing expected", 1'b1, 1'b0);
      end else begin
        want = pending_levels.pop_front();
        if (out_data.line_level !== want.line_level)
          report_mismatch("line_level", out_data.line_level, want.line_level);
        if (out_data.busy_res !== want.busy_res)
          report_mismatch("busy_res", out_data.busy_res, want.busy_res);
        if (out_data.frame_done !== want.frame_done)
          report_mismatch("frame_done", out_data.frame_done, want.frame_done);
      end
    end
  end

  // Bound the run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic                        req;
    logic [wfst_pkg::DATA_W-1:0] word;
    int                          mode;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed sequence
    foreach (DIRECTED[i]) begin
      if (DIRECTED[i].is_cfg) begin
        drain_levels();
        write_reg(DIRECTED[i].idx, DIRECTED[i].wdata);
      end else begin
        repeat (DIRECTED[i].reps)
          send_tick(DIRECTED[i].req, DIRECTED[i].word, DIRECTED[i].typed,
                    DIRECTED[i].level);
      end
    end

    // Random segments, each under its own setting and idling mode
    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      drain_levels();
      mode = seg % 4;
      sender_idle_pct = (mode == 1) ? 73 : (mode == 3) ? 18 : 0;
      stall_pct       = (mode == 2) ? 73 : (mode == 3) ? 18 : 0;
      if (seg < 8) begin
        write_reg(REG_DATA_BYTES, PLAN_BYTES[seg]);
        write_reg(REG_PARITY, PLAN_PARITY[seg]);
        write_reg(REG_STOP_BITS, PLAN_STOPS[seg]);
      end else begin
        write_reg(REG_DATA_BYTES, wfst_pkg::CFG_DATA_W'($urandom_range(0, 7)));
        write_reg(REG_PARITY, wfst_pkg::CFG_DATA_W'($urandom_range(0, 7)));
        write_reg(REG_STOP_BITS, wfst_pkg::CFG_DATA_W'($urandom_range(0, 7)));
      end
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_UNUSED, wfst_pkg::CFG_DATA_W'($urandom_range(0, 7)));

      for (int n = 0; n < SEGMENT_ITEMS; n++) begin
        // Mostly start frames when idle; sometimes request while busy or noise
        if ($urandom_range(0, 9) == 0) req = 1'($urandom_range(0, 1));
        else if (seq_phase == ST_IDLE) req = ($urandom_range(0, 3) != 0);
        else req = ($urandom_range(0, 19) == 0);
        case ($urandom_range(0, 7))
          0:       word = '0;
          1:       word = '1;
          default: word = $urandom;
        endcase
        send_tick(req, word, 1'b0, LVL_NONE);
      end
    end

    drain_levels();
    repeat (8) @(posedge clk);
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
